### src/pgpt_pkg.sv
// shared types, codes and helpers for the photogate pendulum timer
package pgpt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam logic [5:0] STOP_TIMEOUT_RST = 6'd50;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_THR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_NUM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV_NUM  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_TMO  = 2'd3;

    localparam logic [2:0] ACT_GATE  = 3'd0;
    localparam logic [2:0] ACT_TICK  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_RESET = 3'd4;

    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_SHORT   = 2'd1;
    localparam logic [1:0] MODE_LONG    = 2'd2;

    localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;

    localparam logic [1:0] MOT_UNKNOWN = 2'd0;
    localparam logic [1:0] MOT_MOVING  = 2'd1;
    localparam logic [1:0] MOT_STOPPED = 2'd2;

    localparam logic [1:0] PHASE_DONE = 2'd2;

    localparam int DIV_WIDE_STEPS   = 64;
    localparam int DIV_NARROW_STEPS = 32;
    localparam int DIV_CNT_BITS     = $clog2(DIV_WIDE_STEPS + 1);

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  action;
        logic        gate_dark;
        logic [31:0] timestamp;
        logic        source_on;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  swing_mode;
        logic [1:0]  direction;
        logic [1:0]  motion;
        logic [31:0] period_ticks;
        logic [31:0] speed;
        logic [31:0] gravity;
        logic        new_point;
        logic [31:0] recent_half;
        logic [31:0] earlier_half;
    } t_out_item;

    typedef struct packed {
        logic [31:0] short_thr;
        logic [31:0] speed_num;
        logic [63:0] grav_num;
        logic [5:0]  stop_tmo;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic        narrow;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GDIV1,
        ST_GDIV2,
        ST_SDIV,
        ST_PUSH
    } t_state;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (v[63:32] != 32'd0) ? SAT32 : v[31:0];
        return r;
    endfunction

endpackage

### src/pgpt_div.sv
// shared restoring divider, one quotient bit per cycle
module pgpt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pgpt_pkg::t_div_req i_req,
    output pgpt_pkg::t_div_rsp o_rsp
);
    import pgpt_pkg::*;

    logic [31:0]             r_rem, n_rem;
    logic [63:0]             r_quo, n_quo;
    logic [31:0]             r_den, n_den;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;

    logic [32:0] rr;
    logic [32:0] diff;
    logic        ge;

    assign rr   = {r_rem, r_quo[63]};
    assign ge   = rr >= {1'b0, r_den};
    assign diff = rr - {1'b0, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = 32'd0;
            n_den  = i_req.divisor;
            n_busy = 1'b1;
            if (i_req.narrow) begin
                // narrow dividend sits on top so only half the steps are needed
                n_quo = {i_req.dividend[31:0], 32'd0};
                n_cnt = DIV_CNT_BITS'(DIV_NARROW_STEPS);
            end else begin
                n_quo = i_req.dividend;
                n_cnt = DIV_CNT_BITS'(DIV_WIDE_STEPS);
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[31:0] : rr[31:0];
            n_quo = {r_quo[62:0], ge};
            n_cnt = r_cnt - DIV_CNT_BITS'(1);
            if (r_cnt == DIV_CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with empty step count");

endmodule

### src/pgpt_ctrl.sv
// timing state, swing classification and sequencer around the shared divider
module pgpt_ctrl #(
    parameter int TIME_BITS = pgpt_pkg::TIME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pgpt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pgpt_pkg::t_out_item o_out_data,
    input  pgpt_pkg::t_cfg      i_cfg,
    output pgpt_pkg::t_div_req  o_div_req,
    input  pgpt_pkg::t_div_rsp  i_div_rsp
);
    import pgpt_pkg::*;

    t_state    r_state, n_state;
    t_in_item  r_item, n_item;
    t_out_item r_out_data, n_out_data;
    logic      r_out_vld, n_out_vld;

    logic                 r_restart, n_restart;
    logic [TIME_BITS-1:0] r_last_dark, n_last_dark;
    logic [31:0]          r_half_recent, n_half_recent;
    logic [31:0]          r_half_earlier, n_half_earlier;
    logic [1:0]           r_phase, n_phase;
    logic [1:0]           r_mode, n_mode;
    logic [1:0]           r_dir, n_dir;
    logic [1:0]           r_motion, n_motion;
    logic [5:0]           r_cd, n_cd;
    logic                 r_acq, n_acq;
    logic [31:0]          r_period, n_period;
    logic [31:0]          r_speed, n_speed;
    logic [31:0]          r_grav, n_grav;
    logic                 r_point, n_point;

    logic [TIME_BITS-1:0] ts_t;
    logic [TIME_BITS-1:0] span;
    logic [31:0]          span_sat;
    logic [32:0]          half_sum;
    logic                 speed_ok;

    assign ts_t     = TIME_BITS'(r_item.timestamp);
    assign span     = ts_t - r_last_dark;
    assign span_sat = sat32(64'(span));
    assign half_sum = {1'b0, span_sat} + {1'b0, r_half_recent};
    assign speed_ok = (span != '0) && (64'(span) < 64'(i_cfg.short_thr))
                      && (r_mode == MODE_LONG);

    always_comb begin
        n_state        = r_state;
        n_item         = r_item;
        n_out_data     = r_out_data;
        n_out_vld      = r_out_vld;
        n_restart      = r_restart;
        n_last_dark    = r_last_dark;
        n_half_recent  = r_half_recent;
        n_half_earlier = r_half_earlier;
        n_phase        = r_phase;
        n_mode         = r_mode;
        n_dir          = r_dir;
        n_motion       = r_motion;
        n_cd           = r_cd;
        n_acq          = r_acq;
        n_period       = r_period;
        n_speed        = r_speed;
        n_grav         = r_grav;
        n_point        = r_point;
        o_div_req      = '0;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_point = 1'b0;
                n_state = ST_PUSH;
                case (r_item.action)
                    ACT_GATE: begin
                        n_cd     = i_cfg.stop_tmo;
                        n_motion = MOT_MOVING;
                        if (r_restart && r_item.gate_dark) begin
                            n_restart      = 1'b0;
                            n_last_dark    = ts_t;
                            n_half_recent  = 32'd0;
                            n_half_earlier = 32'd0;
                            n_dir          = DIR_UNKNOWN;
                            n_phase        = 2'd0;
                        end else if (r_item.gate_dark) begin
                            n_last_dark    = ts_t;
                            n_half_earlier = r_half_recent;
                            n_half_recent  = span_sat;
                            if (span_sat != 32'd0 && r_half_recent != 32'd0) begin
                                if (span_sat >= i_cfg.short_thr) begin
                                    n_mode   = MODE_SHORT;
                                    n_period = span_sat;
                                    n_dir    = DIR_UNKNOWN;
                                    n_phase  = PHASE_DONE;
                                end else if (r_half_recent >= i_cfg.short_thr) begin
                                    n_mode  = MODE_SHORT;
                                    n_dir   = DIR_UNKNOWN;
                                    n_phase = 2'd0;
                                end else begin
                                    n_mode   = MODE_LONG;
                                    n_period = sat32(64'(half_sum));
                                    n_phase  = r_phase + 2'd1;
                                    n_dir    = (span_sat > r_half_recent) ?
                                               DIR_BACKWARD : DIR_FORWARD;
                                end
                            end
                            if (n_phase == PHASE_DONE) begin
                                n_phase = 2'd0;
                                if (r_acq) begin
                                    // g = numerator / period / period
                                    n_point            = 1'b1;
                                    o_div_req.start    = 1'b1;
                                    o_div_req.narrow   = 1'b0;
                                    o_div_req.dividend = i_cfg.grav_num;
                                    o_div_req.divisor  = n_period;
                                    n_state            = ST_GDIV1;
                                end
                            end
                        end else if (speed_ok) begin
                            o_div_req.start    = 1'b1;
                            o_div_req.narrow   = 1'b1;
                            o_div_req.dividend = {32'd0, i_cfg.speed_num};
                            o_div_req.divisor  = span_sat;
                            n_state            = ST_SDIV;
                        end else begin
                            n_speed = 32'd0;
                        end
                    end
                    ACT_TICK: begin
                        if (r_item.source_on && r_cd != 6'd0) begin
                            n_cd = r_cd - 6'd1;
                        end
                        if (!r_item.source_on) begin
                            n_cd     = i_cfg.stop_tmo;
                            n_motion = MOT_UNKNOWN;
                            n_dir    = DIR_UNKNOWN;
                            n_mode   = MODE_UNKNOWN;
                        end
                        if (n_cd == 6'd0) begin
                            n_motion = MOT_STOPPED;
                            n_dir    = DIR_UNKNOWN;
                            n_mode   = MODE_UNKNOWN;
                        end
                    end
                    ACT_START: begin
                        n_acq = 1'b1;
                    end
                    ACT_STOP: begin
                        n_acq  = 1'b0;
                        n_grav = 32'd0;
                    end
                    ACT_RESET: begin
                        n_restart = 1'b1;
                        n_mode    = MODE_UNKNOWN;
                        n_acq     = 1'b0;
                        n_grav    = 32'd0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_GDIV1: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.narrow   = 1'b0;
                    o_div_req.dividend = i_div_rsp.quotient;
                    o_div_req.divisor  = r_period;
                    n_state            = ST_GDIV2;
                end
            end
            ST_GDIV2: begin
                if (i_div_rsp.done) begin
                    n_grav  = sat32(i_div_rsp.quotient);
                    n_state = ST_PUSH;
                end
            end
            ST_SDIV: begin
                if (i_div_rsp.done) begin
                    n_speed = sat32(i_div_rsp.quotient);
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // output register is free or being emptied this cycle
                if (!r_out_vld || !i_out_stall) begin
                    n_out_data.swing_mode   = r_mode;
                    n_out_data.direction    = r_dir;
                    n_out_data.motion       = r_motion;
                    n_out_data.period_ticks = r_period;
                    n_out_data.speed        = r_speed;
                    n_out_data.gravity      = r_grav;
                    n_out_data.new_point    = r_point;
                    n_out_data.recent_half  = r_half_recent;
                    n_out_data.earlier_half = r_half_earlier;
                    n_out_vld               = 1'b1;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_vld      <= 1'b0;
            r_restart      <= 1'b1;
            r_last_dark    <= '0;
            r_half_recent  <= 32'd0;
            r_half_earlier <= 32'd0;
            r_phase        <= 2'd0;
            r_mode         <= MODE_UNKNOWN;
            r_dir          <= DIR_UNKNOWN;
            r_motion       <= MOT_UNKNOWN;
            r_cd           <= 6'd0;
            r_acq          <= 1'b0;
            r_period       <= 32'd0;
            r_speed        <= 32'd0;
            r_grav         <= 32'd0;
            r_point        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_out_vld      <= n_out_vld;
            r_restart      <= n_restart;
            r_last_dark    <= n_last_dark;
            r_half_recent  <= n_half_recent;
            r_half_earlier <= n_half_earlier;
            r_phase        <= n_phase;
            r_mode         <= n_mode;
            r_dir          <= n_dir;
            r_motion       <= n_motion;
            r_cd           <= n_cd;
            r_acq          <= n_acq;
            r_period       <= n_period;
            r_speed        <= n_speed;
            r_grav         <= n_grav;
            r_point        <= n_point;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    a_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |->
            (r_state == ST_GDIV1 || r_state == ST_GDIV2 || r_state == ST_SDIV))
        else $error("divider result arrived with no one waiting");

endmodule

### src/photogate_pendulum_timer.sv
// photogate pendulum timer: configuration registers and block top level
//
//  channel   direction  signals                                  payload
//  input     in         i_in_valid, o_in_stall, i_in_data        t_in_item
//  result    out        o_out_valid, i_out_stall, o_out_data     t_out_item
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata         register write
//
// one transaction in gives one transaction out; the block takes one item at a time
// ticks, commands and plain gate edges: through the execute and push states, no divider
// light edge in long swing, span under the short threshold: one 32-step divider pass
// period completed while acquiring: two 64-step divider passes
// synchronous active-low reset; the input is taken again once the result is
// loaded, even while a stalled result transaction still waits to be taken
module photogate_pendulum_timer #(
    parameter int TIME_BITS = pgpt_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  pgpt_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output pgpt_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [pgpt_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [pgpt_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import pgpt_pkg::*;

    logic [31:0] r_short_thr;
    logic [31:0] r_speed_num;
    logic [63:0] r_grav_num;
    logic [5:0]  r_stop_tmo;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= 32'd0;
            r_speed_num <= 32'd0;
            r_grav_num  <= 64'd0;
            r_stop_tmo  <= STOP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_THR: r_short_thr <= i_cfg_wdata[31:0];
                CFG_SPEED_NUM: r_speed_num <= i_cfg_wdata[31:0];
                CFG_GRAV_NUM:  r_grav_num  <= i_cfg_wdata[63:0];
                CFG_STOP_TMO:  r_stop_tmo  <= i_cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.short_thr = r_short_thr;
    assign cfg.speed_num = r_speed_num;
    assign cfg.grav_num  = r_grav_num;
    assign cfg.stop_tmo  = r_stop_tmo;

    pgpt_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg       (cfg),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    pgpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
